/* hw/rtl/h264dep_pkg.sv */
// ----------------------------------------------------------------------------
// h264dep_pkg: shared types and constants of the H.264 RTP depacketizer
// Holds the RTP header length, the queue geometry, the Annex-B start code
// and the command word that the parser hands to the byte emitter.
// ----------------------------------------------------------------------------
package h264dep_pkg;

   // Fixed RTP header length in bytes
   localparam int HEADER_BYTES = 12;
   localparam int HC_W         = 7;

   // Command queue between parser and emitter
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // NAL unit types with special handling
   localparam logic [4:0] NAL_SINGLE_MIN = 5'd1;
   localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
   localparam logic [4:0] NAL_STAP_A     = 5'd24;
   localparam logic [4:0] NAL_FU_A       = 5'd28;

   // Annex-B start code, emitted in index order
   localparam logic [7:0] ANNEXB_PREFIX [4] = '{8'h00, 8'h00, 8'h00, 8'h01};
   localparam logic [2:0] START_LEN         = 3'd4;

   // One parsed input byte: what the emitter must produce for it
   typedef struct packed {
      logic [7:0] data;       // byte written after the optional start code
      logic       has_start;  // write 00 00 00 01 first
      logic       has_byte;   // write data
      logic       close;      // last result closes the unit
   } cmd_type;

endpackage

/* hw/rtl/h264_rtp_depacketizer.sv */
// ----------------------------------------------------------------------------
// h264_rtp_depacketizer: H.264 RTP to Annex-B byte stream converter
// Strips the RTP header and rebuilds single NAL, STAP-A and FU-A payloads
// into a start-code delimited byte stream.
//
//   channel   ports                                      direction
//   req       req_push/req_full, in_byte, first/last     in,  1 beat per byte
//   rsp       rsp_pop/rsp_empty, out_byte, byte_valid,   out, up to 5 beats
//             unit_end, run_last                              per input byte
//
// A packet byte is accepted every cycle while the command queue has room.
// A byte with a start code expands to 4 or 5 result beats in the emitter,
// so start-code bursts fill the 4-entry queue and raise req_full until the
// emitter drains. A byte's first result passes the queue slot, then the
// output register. Synchronous reset returns the parser to idle and empties
// the queue and output register. A stalled rsp_pop holds the current beat.
// ----------------------------------------------------------------------------
module h264_rtp_depacketizer
   import h264dep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_unit_end,
   output logic       rsp_run_last
);

   logic    cmd_push;
   cmd_type cmd;
   logic    q_full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    q_pop;

   assign req_full = q_full;

   h264dep_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_in_byte    (req_in_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .q_full         (q_full),
      .cmd_push       (cmd_push),
      .cmd            (cmd)
   );

   h264dep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   h264dep_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_unit_end   (rsp_unit_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

/* hw/rtl/h264dep_front.sv */
// ----------------------------------------------------------------------------
// h264dep_front: packet parser
// Tracks the RTP header, the NAL header and the STAP-A / FU-A structure of
// each packet, one byte per cycle while the queue has room, and issues one
// command per input byte that produces results.
// ----------------------------------------------------------------------------
module h264dep_front
   import h264dep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_in_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   input  logic       q_full,
   output logic       cmd_push,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_HDR, PH_NALHDR, PH_FUHDR, PH_BODY, PH_SIZE_HI, PH_SIZE_LO, PH_NALDATA
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE, KIND_SINGLE, KIND_STAP, KIND_FU
   } kind_type;

   phase_type   phase_ff, phase_in, phase_cur;
   kind_type    kind_ff, kind_in, kind_cur;
   logic [HC_W-1:0] hc_ff, hc_in, hc_cur, hc_inc;
   logic        fef_ff, fef_in, fef_cur;
   logic [1:0]  prio_ff, prio_in;
   logic [15:0] rem_ff, rem_in, rem_dec, rem_new;
   logic [7:0]  shb_ff, shb_in;
   logic [4:0]  nal_type;
   logic        accept;
   logic        close;

   assign accept = req_push && !q_full;

   // Classify the byte and compute the next parse state
   always_comb begin
      phase_cur = req_first_byte ? PH_HDR : phase_ff;
      kind_cur  = req_first_byte ? KIND_NONE : kind_ff;
      fef_cur   = req_first_byte ? 1'b0 : fef_ff;
      hc_cur    = req_first_byte ? '0 : hc_ff;
      hc_inc    = hc_cur + HC_W'(1);
      nal_type  = req_in_byte[4:0];
      rem_dec   = rem_ff - 16'd1;
      rem_new   = {shb_ff, req_in_byte};

      phase_in  = phase_cur;
      kind_in   = kind_cur;
      fef_in    = fef_cur;
      hc_in     = hc_cur;
      prio_in   = prio_ff;
      rem_in    = rem_ff;
      shb_in    = shb_ff;
      close     = 1'b0;
      cmd       = '0;

      unique case (phase_cur)
         PH_IDLE: begin
         end
         PH_HDR: begin
            hc_in = hc_inc;
            if (hc_inc >= HC_W'(HEADER_BYTES)) begin
               phase_in = PH_NALHDR;
            end
         end
         PH_NALHDR: begin
            prio_in = req_in_byte[6:5];
            priority if (nal_type >= NAL_SINGLE_MIN && nal_type <= NAL_SINGLE_MAX) begin
               kind_in       = KIND_SINGLE;
               cmd.has_start = 1'b1;
               cmd.has_byte  = 1'b1;
               cmd.data      = req_in_byte;
               phase_in      = PH_BODY;
               close         = req_last_byte;
            end else if (nal_type == NAL_STAP_A) begin
               kind_in  = KIND_STAP;
               phase_in = PH_SIZE_HI;
               close    = req_last_byte;
            end else if (nal_type == NAL_FU_A) begin
               kind_in  = KIND_FU;
               phase_in = PH_FUHDR;
            end else begin
               kind_in  = KIND_NONE;
               phase_in = PH_IDLE;
            end
         end
         PH_FUHDR: begin
            fef_in = req_in_byte[6];
            if (req_in_byte[7]) begin
               cmd.has_start = 1'b1;
               cmd.has_byte  = 1'b1;
               cmd.data      = {1'b0, prio_ff, req_in_byte[4:0]};
            end
            phase_in = PH_BODY;
            close    = req_last_byte && req_in_byte[6];
         end
         PH_BODY: begin
            cmd.has_byte = 1'b1;
            cmd.data     = req_in_byte;
            close        = req_last_byte && (kind_cur != KIND_FU || fef_cur);
         end
         PH_SIZE_HI: begin
            shb_in   = req_in_byte;
            phase_in = PH_SIZE_LO;
            close    = req_last_byte;
         end
         PH_SIZE_LO: begin
            rem_in        = rem_new;
            cmd.has_start = 1'b1;
            phase_in      = (rem_new == 16'd0) ? PH_SIZE_HI : PH_NALDATA;
            close         = req_last_byte;
         end
         PH_NALDATA: begin
            cmd.has_byte = 1'b1;
            cmd.data     = req_in_byte;
            rem_in       = rem_dec;
            if (rem_dec == 16'd0) begin
               phase_in = PH_SIZE_HI;
            end
            close = req_last_byte;
         end
      endcase

      // Leave the packet on its last byte
      if (req_last_byte) begin
         phase_in = PH_IDLE;
         kind_in  = KIND_NONE;
      end

      cmd.close = close;
      cmd_push  = accept && (cmd.has_start || cmd.has_byte || close);
   end

   // Hold parse state; advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= KIND_NONE;
         hc_ff    <= '0;
         fef_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         hc_ff    <= hc_in;
         fef_ff   <= fef_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prio_ff <= prio_in;
         rem_ff  <= rem_in;
         shb_ff  <= shb_in;
      end
   end

endmodule

/* hw/rtl/h264dep_queue.sv */
// ----------------------------------------------------------------------------
// h264dep_queue: command queue
// Short FIFO of parser commands that decouples the parser from the
// byte emitter, so a start-code burst does not stall the input at once.
// ----------------------------------------------------------------------------
module h264dep_queue
   import h264dep_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type                slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]      count_ff;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slots_ff[rd_ptr_ff];

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QUEUE_AW+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QUEUE_AW+1)'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("command pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("command popped from an empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

/* hw/rtl/h264dep_back.sv */
// ----------------------------------------------------------------------------
// h264dep_back: byte emitter
// Expands each queued command into its result beats (start code, data
// byte or bare end marker) and keeps the current beat in an output register.
// ----------------------------------------------------------------------------
module h264dep_back
   import h264dep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       q_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_unit_end,
   output logic       rsp_run_last
);

   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bv_ff, bv_in, ue_ff, ue_in, rl_ff, rl_in;
   logic [2:0] last_idx;
   logic       is_last;
   logic       load;

   // Pick the beat at the current index of the head command
   always_comb begin
      if (head_cmd.has_start) begin
         last_idx = head_cmd.has_byte ? START_LEN : START_LEN - 3'd1;
      end else begin
         last_idx = 3'd0;
      end
      is_last = (idx_ff == last_idx);

      if (head_cmd.has_start && idx_ff < START_LEN) begin
         byte_in = ANNEXB_PREFIX[idx_ff[1:0]];
         bv_in   = 1'b1;
      end else if (head_cmd.has_byte) begin
         byte_in = head_cmd.data;
         bv_in   = 1'b1;
      end else begin
         byte_in = 8'h00;
         bv_in   = 1'b0;
      end
      ue_in = head_cmd.close && is_last;
      rl_in = is_last;

      load   = head_valid && (!out_valid_ff || rsp_pop);
      q_pop  = load && is_last;
      idx_in = is_last ? 3'd0 : idx_ff + 3'd1;

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Advance the beat index and the output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (load) begin
            idx_ff <= idx_in;
         end
      end
   end

   // Hold the result beat until popped
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         bv_ff   <= bv_in;
         ue_ff   <= ue_in;
         rl_ff   <= rl_in;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bv_ff;
   assign rsp_unit_end   = ue_ff;
   assign rsp_run_last   = rl_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset) idx_ff <= START_LEN)
      else $error("beat index out of range");
   a_bare_closes: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !bv_ff) |-> (ue_ff && rl_ff && byte_ff == 8'h00))
      else $error("bare marker does not close a unit");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && ue_ff) |-> rl_ff)
      else $error("unit end on a beat that is not the last of its byte");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: H.264 RTP depacketizer check
// Feeds RTP packet bytes (single NAL, STAP-A, FU-A, dropped types, short and
// abandoned packets, stray bytes) through the push/full port, predicts the
// Annex-B beat stream in a behavioral parser and compares every popped beat
// in order. In the first two of three phases sender and receiver stall.
// ----------------------------------------------------------------------------
module testbench;
   import h264dep_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_BYTES = 42;   // at least, per phase
   localparam int REPORT_MAX   = 10;

   // Packet shapes of the random stimulus
   localparam int SHAPE_SINGLE  = 0;
   localparam int SHAPE_STAP    = 1;
   localparam int SHAPE_FU      = 2;
   localparam int SHAPE_DROPPED = 3;
   localparam int SHAPE_SHORT   = 4;
   localparam int SHAPE_ABANDON = 5;
   localparam int SHAPE_COUNT   = 6;

   typedef enum logic [2:0] {
      PARSE_IDLE, PARSE_RTP_HDR, PARSE_NAL_HDR, PARSE_FU_HDR,
      PARSE_PAYLOAD, PARSE_LEN_HI, PARSE_LEN_LO, PARSE_AGG_NAL
   } parse_state_type;

   typedef enum logic [1:0] {
      PKT_NONE, PKT_SINGLE, PKT_STAP_A, PKT_FU_A
   } packet_kind_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_first;
      logic       is_last;
   } packet_byte_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       valid;
      logic       unit_end;
      logic       run_last;
   } stream_beat_type;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_in_byte;
   logic       req_first_byte;
   logic       req_last_byte;
   logic       rsp_pop;
   logic       rsp_empty;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_unit_end;
   logic       rsp_run_last;

   packet_byte_type pending_bytes [$];
   packet_byte_type held_byte;
   logic            byte_held;
   logic [7:0]      pkt_bytes [$];
   stream_beat_type byte_run [$];
   stream_beat_type annexb_expect [$];

   int send_idle_pct;
   int recv_idle_pct;
   int queued_bytes;
   int shape_idx;
   int errors;
   int cycles;

   // Parser state of the predictor
   parse_state_type parse_state;
   packet_kind_type pkt_kind;
   logic [6:0]      rtp_hdr_seen;
   logic [1:0]      nri_bits;
   logic [15:0]     agg_left;
   logic [7:0]      len_hi;
   logic            fu_end_seen;

   h264_rtp_depacketizer uut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_byte    (req_in_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_unit_end   (rsp_unit_end),
      .rsp_run_last   (rsp_run_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic stream_beat_type data_beat(input logic [7:0] b);
      stream_beat_type beat;
      beat.out_byte = b;
      beat.valid    = 1'b1;
      beat.unit_end = 1'b0;
      beat.run_last = 1'b0;
      return beat;
   endfunction

   task automatic add_start_code();
      for (int i = 0; i < 4; i++) begin
         byte_run.push_back(data_beat(ANNEXB_PREFIX[i]));
      end
   endtask

   // Predict the beats that one accepted packet byte produces
   task automatic depacketize_byte(input logic [7:0] b, input logic first,
                                   input logic last);
      logic            closing;
      stream_beat_type marker;
      closing = 1'b0;
      byte_run.delete();
      if (first) begin
         parse_state  = PARSE_RTP_HDR;
         rtp_hdr_seen = '0;
         pkt_kind     = PKT_NONE;
         fu_end_seen  = 1'b0;
      end
      case (parse_state)
         PARSE_RTP_HDR: begin
            rtp_hdr_seen = rtp_hdr_seen + 7'd1;
            if (rtp_hdr_seen >= HEADER_BYTES) parse_state = PARSE_NAL_HDR;
         end
         PARSE_NAL_HDR: begin
            nri_bits = b[6:5];
            if (b[4:0] >= NAL_SINGLE_MIN && b[4:0] <= NAL_SINGLE_MAX) begin
               pkt_kind = PKT_SINGLE;
               add_start_code();
               byte_run.push_back(data_beat(b));
               parse_state = PARSE_PAYLOAD;
               closing     = last;
            end else if (b[4:0] == NAL_STAP_A) begin
               pkt_kind    = PKT_STAP_A;
               parse_state = PARSE_LEN_HI;
               closing     = last;
            end else if (b[4:0] == NAL_FU_A) begin
               pkt_kind    = PKT_FU_A;
               parse_state = PARSE_FU_HDR;
            end else begin
               pkt_kind    = PKT_NONE;
               parse_state = PARSE_IDLE;
            end
         end
         PARSE_FU_HDR: begin
            fu_end_seen = b[6];
            // rebuild the NAL header on a start fragment
            if (b[7]) begin
               add_start_code();
               byte_run.push_back(data_beat({1'b0, nri_bits, b[4:0]}));
            end
            parse_state = PARSE_PAYLOAD;
            closing     = last && fu_end_seen;
         end
         PARSE_PAYLOAD: begin
            byte_run.push_back(data_beat(b));
            closing = (pkt_kind == PKT_FU_A) ? (last && fu_end_seen) : last;
         end
         PARSE_LEN_HI: begin
            len_hi      = b;
            parse_state = PARSE_LEN_LO;
            closing     = last;
         end
         PARSE_LEN_LO: begin
            agg_left = {len_hi, b};
            add_start_code();
            parse_state = (agg_left == 16'd0) ? PARSE_LEN_HI : PARSE_AGG_NAL;
            closing     = last;
         end
         PARSE_AGG_NAL: begin
            byte_run.push_back(data_beat(b));
            agg_left = agg_left - 16'd1;
            if (agg_left == 16'd0) parse_state = PARSE_LEN_HI;
            closing = last;
         end
         default: begin
         end
      endcase
      // close the unit, with a bare marker when nothing was written
      if (closing) begin
         if (byte_run.size() == 0) begin
            marker = '0;
            byte_run.push_back(marker);
         end
         byte_run[byte_run.size() - 1].unit_end = 1'b1;
      end
      if (last) begin
         parse_state = PARSE_IDLE;
         pkt_kind    = PKT_NONE;
      end
      if (byte_run.size() != 0) byte_run[byte_run.size() - 1].run_last = 1'b1;
      foreach (byte_run[i]) annexb_expect.push_back(byte_run[i]);
   endtask

   task automatic note_error(input string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("%s", msg);
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic first, input logic last);
      packet_byte_type pb;
      pb.data     = b;
      pb.is_first = first;
      pb.is_last  = last;
      pending_bytes.push_back(pb);
      queued_bytes++;
   endtask

   // Send a random RTP header and pkt_bytes; 0 < keep < total cuts it short
   task automatic send_packet(input int keep, input logic closed);
      int         total;
      logic [7:0] b;
      total = HEADER_BYTES + pkt_bytes.size();
      if (keep > 0 && keep < total) total = keep;
      for (int i = 0; i < total; i++) begin
         b = (i < HEADER_BYTES) ? 8'($urandom) : pkt_bytes[i - HEADER_BYTES];
         queue_byte(b, i == 0, closed && i == total - 1);
      end
   endtask

   task automatic add_packet(input int shape);
      int         n_nal;
      int         len;
      int         declared;
      int         idx;
      int         keep;
      logic [7:0] b;
      pkt_bytes.delete();
      keep = 0;
      b    = 8'($urandom);
      case (shape)
         SHAPE_SINGLE, SHAPE_ABANDON: begin
            b[4:0] = 5'($urandom_range(NAL_SINGLE_MIN, NAL_SINGLE_MAX));
            pkt_bytes.push_back(b);
            repeat ($urandom_range(0, 5)) pkt_bytes.push_back(8'($urandom));
            if (shape == SHAPE_ABANDON) begin
               keep = $urandom_range(1, HEADER_BYTES + pkt_bytes.size());
            end
         end
         SHAPE_STAP: begin
            b[4:0] = NAL_STAP_A;
            pkt_bytes.push_back(b);
            n_nal = $urandom_range(0, 2);
            for (int k = 0; k < n_nal; k++) begin
               len      = $urandom_range(0, 3);
               declared = len;
               // let the last NAL run past the packet end now and then
               if (k == n_nal - 1 && $urandom_range(0, 3) == 0) begin
                  declared = len + $urandom_range(1, 400);
               end
               pkt_bytes.push_back(8'(declared >> 8));
               pkt_bytes.push_back(8'(declared));
               repeat (len) pkt_bytes.push_back(8'($urandom));
            end
            // lone size high byte at the packet end
            if ($urandom_range(0, 3) == 0) pkt_bytes.push_back(8'($urandom));
         end
         SHAPE_FU: begin
            b[4:0] = NAL_FU_A;
            pkt_bytes.push_back(b);
            if ($urandom_range(0, 9) != 0) begin
               pkt_bytes.push_back(8'($urandom));
               repeat ($urandom_range(0, 4)) pkt_bytes.push_back(8'($urandom));
            end
         end
         SHAPE_DROPPED: begin
            idx    = $urandom_range(0, 6);
            b[4:0] = (idx == 0) ? 5'd0 : (idx <= 3) ? 5'(24 + idx) : 5'(25 + idx);
            pkt_bytes.push_back(b);
            repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
         end
         default: begin
            keep = $urandom_range(1, HEADER_BYTES);
         end
      endcase
      send_packet(keep, shape != SHAPE_ABANDON);
      // stray bytes between packets
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 2)) queue_byte(8'($urandom), 1'b0, 1'($urandom));
      end
   endtask

   // Driver: present one byte at a time, hold it until the block takes it
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            depacketize_byte(held_byte.data, held_byte.is_first, held_byte.is_last);
            byte_held = 1'b0;
         end
         if (!byte_held) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               held_byte = pending_bytes.pop_front();
               byte_held = 1'b1;
               req_in_byte    <= held_byte.data;
               req_first_byte <= held_byte.is_first;
               req_last_byte  <= held_byte.is_last;
               req_push       <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each popped beat with the oldest predicted one
   always @(posedge clock) begin : rsp_monitor
      stream_beat_type seen;
      stream_beat_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            seen.out_byte = rsp_out_byte;
            seen.valid    = rsp_byte_valid;
            seen.unit_end = rsp_unit_end;
            seen.run_last = rsp_run_last;
            if (annexb_expect.size() == 0) begin
               note_error($sformatf("unexpected beat: byte %h valid %b end %b run_last %b",
                                    seen.out_byte, seen.valid, seen.unit_end,
                                    seen.run_last));
            end else begin
               want = annexb_expect.pop_front();
               if (seen !== want) begin
                  note_error($sformatf({"beat mismatch: byte %h/%h valid %b/%b ",
                                        "end %b/%b run_last %b/%b (expected/actual)"},
                                       want.out_byte, seen.out_byte, want.valid,
                                       seen.valid, want.unit_end, seen.unit_end,
                                       want.run_last, seen.run_last));
               end
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Hard stop on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_in_byte    = 8'h00;
      req_first_byte = 1'b0;
      req_last_byte  = 1'b0;
      rsp_pop        = 1'b0;
      byte_held      = 1'b0;
      errors         = 0;
      cycles         = 0;
      queued_bytes   = 0;
      send_idle_pct  = 29;
      recv_idle_pct  = 83;
      shape_idx      = $urandom_range(0, SHAPE_COUNT - 1);
      parse_state    = PARSE_IDLE;
      pkt_kind       = PKT_NONE;
      rtp_hdr_seen   = '0;
      nri_bits       = '0;
      agg_left       = '0;
      len_hi         = '0;
      fu_end_seen    = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 83 : 0;
         recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 29 : 0;
         if (ph == 0) begin
            // stray bytes, a one-byte packet, then a STAP-A with a zero
            // size, one NAL and a lone size high byte at the end
            queue_byte(8'h00, 1'b0, 1'b0);
            queue_byte(8'hFF, 1'b0, 1'b1);
            queue_byte(8'hFF, 1'b1, 1'b1);
            pkt_bytes = '{8'h78, 8'h00, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55, 8'h01};
            send_packet(0, 1'b1);
         end
         queued_bytes = 0;
         while (queued_bytes < RANDOM_BYTES) begin
            add_packet(shape_idx % SHAPE_COUNT);
            shape_idx++;
         end
         // hold until every byte is taken and every beat has come out
         while (pending_bytes.size() != 0 || byte_held || annexb_expect.size() != 0) begin
            @(posedge clock);
         end
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (annexb_expect.size() != 0) begin
         note_error($sformatf("%0d expected beats never arrived", annexb_expect.size()));
      end
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/h264dep_pkg.sv
hw/rtl/h264dep_front.sv
hw/rtl/h264dep_queue.sv
hw/rtl/h264dep_back.sv
hw/rtl/h264_rtp_depacketizer.sv
tb/testbench.sv
